// File: hdl/sliding_window_min_max_defines.svh
// ----------------------------------------------------------------------------
// sliding_window_min_max assertion macros
// shared property forms for the checker of the min / max filter
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SWMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SWMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// types and constants shared by the sliding window min / max filter
// ----------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int CFG_W    = 7;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CFG_W-1:0]           cfg_t;

	// partial min / max travelling down the cell chain
	typedef struct packed {
		logic    valid;
		sample_t lo;
		sample_t hi;
	} token_t;

	// control broadcast to every cell
	typedef struct packed {
		logic shift;
		logic step;
		logic flush;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/swmm_in_if.sv
// ----------------------------------------------------------------------------
// swmm_in_if
// sample channel: valid / ready handshake carrying sample and restart
// ----------------------------------------------------------------------------
`default_nettype none

interface swmm_in_if
	import swmm_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

// File: hdl/swmm_out_if.sv
// ----------------------------------------------------------------------------
// swmm_out_if
// result channel: valid / ready handshake carrying window min and max
// ----------------------------------------------------------------------------
`default_nettype none

interface swmm_out_if
	import swmm_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t window_min;
	sample_t window_max;

	modport source (output valid, output window_min, output window_max, input ready);
	modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

`default_nettype wire

// File: hdl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// one chain cell: holds one sample and folds it into a passing min / max token
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_cell
	import swmm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire sample_t   d_in,
	output sample_t        d_out,
	input  wire token_t    tok_in,
	output token_t         tok_out
);

	sample_t d_q;
	sample_t val;
	logic    tok_valid_q;
	sample_t tok_lo_q;
	sample_t tok_hi_q;

	// value this cell holds after the edge
	assign val = ctl.shift ? d_in : d_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			d_q <= d_in;
		end
		if (ctl.step) begin
			tok_lo_q <= (tok_in.lo < val) ? tok_in.lo : val;
			tok_hi_q <= (tok_in.hi > val) ? tok_in.hi : val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (ctl.flush) begin
			tok_valid_q <= 1'b0;
		end else if (ctl.step) begin
			tok_valid_q <= tok_in.valid;
		end
	end

	assign d_out   = d_q;
	assign tok_out = '{valid: tok_valid_q, lo: tok_lo_q, hi: tok_hi_q};

endmodule

`default_nettype wire

// File: hdl/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max
// sliding-window minimum / maximum filter on a chain of sample cells
// ----------------------------------------------------------------------------
// samples: valid / ready channel, one signed 32-bit sample and a restart flag
//   per item; restart makes the item the first of a new sequence
// results: valid / ready channel, window_min and window_max of the last
//   window_length samples, one item per sample once the window is full
// cfg_we / cfg_data: writes window_length (0 acts as 1, above MAX_WINDOW acts
//   as MAX_WINDOW); write only while the block is idle
// each accepted sample shifts into a chain of MAX_WINDOW cells; when a result
//   is due a token walks down the chain one cell per cycle, folding each
//   cell's sample into its min / max
// result path: the token enters the head cell with its sample and is loaded
//   into the output register from cell L-1, L = effective window length
// sample port: a sample that yields no result leaves it open; one that yields
//   a result closes it for the token walk, until the result is loaded into
//   the output register
// receiver stall: the output register holds the result; the next token waits
//   at cell L-1 and the sample port stays closed until the register frees
// reset: window_length returns to 1, fill count clears, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_max
	import swmm_pkg::*;
#(
	parameter int MAX_WINDOW = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire cfg_t       cfg_data,
	swmm_in_if.sink         samples,
	swmm_out_if.source      results
);

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
	localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_WINDOW);
	localparam logic [LEN_W-1:0] MAX_F = LEN_W'(MAX_WINDOW);

	cfg_t             wlen_q;
	logic [LEN_W-1:0] fill_q;
	logic             busy_q;
	logic [IDX_W-1:0] len_idx_q;
	logic             out_valid_q;
	sample_t          out_min_q;
	sample_t          out_max_q;

	logic [CMP_W-1:0] wl_ext;
	logic [CMP_W-1:0] eff_len;
	logic [LEN_W-1:0] fill_base;
	logic [LEN_W-1:0] fill_new;
	logic             due;
	logic             in_acc;
	logic             at_end;
	logic             out_free;
	logic             load;
	cell_ctl_t        ctl;
	token_t           tok_inject;
	token_t           tok_sel;

	sample_t d_a   [MAX_WINDOW];
	token_t  tok_a [MAX_WINDOW];

	// effective window length and fill count after this item
	always_comb begin
		wl_ext = CMP_W'(wlen_q);
		if (wl_ext == '0) begin
			eff_len = CMP_W'(1);
		end else if (wl_ext > MAX_C) begin
			eff_len = MAX_C;
		end else begin
			eff_len = wl_ext;
		end
		fill_base = samples.restart ? '0 : fill_q;
		fill_new  = (fill_base < MAX_F) ? fill_base + LEN_W'(1) : fill_base;
		due       = CMP_W'(fill_new) >= eff_len;
	end

	assign samples.ready = !busy_q;
	assign in_acc        = samples.valid && !busy_q;

	assign tok_sel  = tok_a[len_idx_q];
	assign at_end   = busy_q && tok_sel.valid;
	assign out_free = !out_valid_q || results.ready;
	assign load     = at_end && out_free;

	assign ctl.shift = in_acc;
	assign ctl.step  = in_acc || (busy_q && !at_end);
	assign ctl.flush = load;

	assign tok_inject = '{valid: in_acc && due, lo: samples.sample, hi: samples.sample};

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		if (k == 0) begin : g_head
			swmm_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.d_in    (samples.sample),
				.d_out   (d_a[k]),
				.tok_in  (tok_inject),
				.tok_out (tok_a[k])
			);
		end else begin : g_body
			swmm_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.d_in    (d_a[k-1]),
				.d_out   (d_a[k]),
				.tok_in  (tok_a[k-1]),
				.tok_out (tok_a[k])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q      <= CFG_RESET;
			fill_q      <= '0;
			busy_q      <= 1'b0;
			len_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wlen_q <= cfg_data;
			end
			if (in_acc) begin
				fill_q    <= fill_new;
				len_idx_q <= IDX_W'(eff_len - CMP_W'(1));
				if (due) begin
					busy_q <= 1'b1;
				end
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_min_q <= tok_sel.lo;
			out_max_q <= tok_sel.hi;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.window_min = out_min_q;
	assign results.window_max = out_max_q;

endmodule

`default_nettype wire

// File: hdl/swmm_check.sv
// ----------------------------------------------------------------------------
// swmm_check
// port-level checker for the sliding window min / max filter, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_min_max_defines.svh"

module swmm_check
	import swmm_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    s_valid,
	input wire logic    s_ready,
	input wire logic    r_valid,
	input wire logic    r_ready,
	input wire sample_t r_min,
	input wire sample_t r_max
);

	// a held result stays offered
	`SWMM_ASSERT_NEXT(a_res_hold, clk, arst_n, r_valid && !r_ready, r_valid, "result dropped while stalled")

	// a held result keeps its payload
	`SWMM_ASSERT_NEXT(a_res_stable, clk, arst_n, r_valid && !r_ready, $stable(r_min) && $stable(r_max), "result changed while stalled")

	// min never exceeds max
	`SWMM_ASSERT_NOW(a_order, clk, arst_n, r_valid, r_min <= r_max, "window min above window max")

	// the sample port only closes after taking an item
	`SWMM_ASSERT_NOW(a_ready_fall, clk, arst_n, $fell(s_ready), $past(s_valid && s_ready), "sample port closed without an item")

endmodule

bind sliding_window_min_max swmm_check u_swmm_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (samples.valid),
	.s_ready (samples.ready),
	.r_valid (results.valid),
	.r_ready (results.ready),
	.r_min   (results.window_min),
	.r_max   (results.window_max)
);

`default_nettype wire

// File: sim/sliding_window_min_max_checker.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_checker
// watches the sample and result channels, keeps its own window history and
// compares every result item against the min / max it predicts
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_window_min_max_checker
	import swmm_pkg::*;
#(
	parameter int MAX_WINDOW = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire cfg_t cfg_data,
	swmm_in_if        samples,
	swmm_out_if       results,
	output int        errors,
	output int        pending,
	output int        checked
);

	localparam int SHOW_LIMIT = 30;

	typedef struct {
		sample_t lo;
		sample_t hi;
	} extremes_t;

	extremes_t minmax_due [$];
	sample_t   history [MAX_WINDOW];
	cfg_t      win_len;
	int        fill;
	int        wr_pos;

	// 0 acts as 1, anything past the chain length is clipped
	function automatic int window_span(cfg_t l);
		if (l == '0)
			return 1;
		if (int'(l) > MAX_WINDOW)
			return MAX_WINDOW;
		return int'(l);
	endfunction

	task automatic fold_sample(input sample_t s, input logic rs);
		int        span;
		sample_t   v;
		extremes_t mm;
		span = window_span(win_len);
		if (rs) begin
			fill = 0;
			wr_pos = 0;
		end
		history[wr_pos] = s;
		if (fill < MAX_WINDOW)
			fill++;
		if (fill >= span) begin
			mm.lo = s;
			mm.hi = s;
			for (int i = 1; i < span; i++) begin
				v = history[(wr_pos + MAX_WINDOW - i) % MAX_WINDOW];
				if (v < mm.lo)
					mm.lo = v;
				if (v > mm.hi)
					mm.hi = v;
			end
			minmax_due = {minmax_due, mm};
		end
		wr_pos = (wr_pos + 1) % MAX_WINDOW;
	endtask

	task automatic check_field(input string name, input sample_t want, input sample_t got);
		if (got !== want) begin
			errors++;
			if (errors <= SHOW_LIMIT)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		extremes_t mm;
		if (!arst_n) begin
			win_len = CFG_RESET;
			fill = 0;
			wr_pos = 0;
			minmax_due.delete();
		end else begin
			if (cfg_we)
				win_len = cfg_data;
			if (samples.valid && samples.ready)
				fold_sample(samples.sample, samples.restart);
			if (results.valid && results.ready) begin
				if (minmax_due.size() == 0) begin
					errors++;
					if (errors <= SHOW_LIMIT)
						$display("%0t: unexpected result, expected none, got min %0d max %0d",
							$time, results.window_min, results.window_max);
				end else begin
					mm = minmax_due.pop_front();
					check_field("window_min", mm.lo, results.window_min);
					check_field("window_max", mm.hi, results.window_max);
					checked++;
				end
			end
		end
		pending = minmax_due.size();
	end

endmodule

// File: sim/sliding_window_min_max_test.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_test
// drives sample items with random gaps and restarts through a range of window
// lengths, stalls the result side at random and lets the checker judge
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_window_min_max_test;
	import swmm_pkg::*;

	localparam int MAX_WINDOW      = 64;
	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 9;
	localparam int DRAIN_CYCLES    = MAX_WINDOW + 8;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int RANDOM_PHASES   = 10;
	localparam int ITEMS_PER_PHASE = 70;
	localparam int MAX_GAP         = 10;

	localparam sample_t SAMPLE_MIN = sample_t'(32'h8000_0000);
	localparam sample_t SAMPLE_MAX = sample_t'(32'h7fff_ffff);
	localparam sample_t BIG_POS    = sample_t'(1000000);
	localparam sample_t BIG_NEG    = sample_t'(-1000000);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_t cfg_data = '0;

	int fail_count;
	int pending;
	int checked;
	int items_sent = 0;
	int settings_used = 0;
	int stuck = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;

	swmm_in_if  sample_ch ();
	swmm_out_if result_ch ();

	always #(CLK_PERIOD / 2) clk = ~clk;

	sliding_window_min_max #(
		.MAX_WINDOW(MAX_WINDOW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.samples(sample_ch),
		.results(result_ch)
	);

	sliding_window_min_max_checker #(
		.MAX_WINDOW(MAX_WINDOW)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.samples(sample_ch),
		.results(result_ch),
		.errors(fail_count),
		.pending(pending),
		.checked(checked)
	);

	function automatic sample_t corner_value(int k);
		case (k)
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return '0;
			3: return sample_t'(-1);
			4: return sample_t'(1);
			5: return BIG_POS;
			default: return BIG_NEG;
		endcase
	endfunction

	// small values make ties and near-equal windows common
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return corner_value($urandom_range(0, 6));
			1, 2, 3: return sample_t'(int'($urandom_range(0, 15)) - 8);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic int pick_length(int p);
		case (p)
			0: return 0;
			1: return MAX_WINDOW;
			2: return 127;
			3: return 2;
			4: return MAX_WINDOW + 1;
			default: begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: return $urandom_range(1, 8);
					6: return $urandom_range(9, 32);
					7: return $urandom_range(33, MAX_WINDOW);
					8: return 0;
					default: return $urandom_range(MAX_WINDOW + 1, 127);
				endcase
			end
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input sample_t s, input logic rs);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		sample_ch.restart <= rs;
		do
			@(posedge clk);
		while (!(sample_ch.valid && sample_ch.ready));
		@(negedge clk);
		items_sent++;
	endtask

	task automatic hold_until_drained();
		sample_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// let the block sit idle for a while before the length changes
	task automatic set_window_length(input int len);
		sample_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= cfg_t'(len);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	always begin : result_sink
		int gap;
		gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			result_ch.ready <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		result_ch.ready <= 1'b1;
		do
			@(posedge clk);
		while (!(result_ch.valid && result_ch.ready));
		@(negedge clk);
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= WATCHDOG_CYCLES) begin
			$display("%0t: watchdog, no item moved for %0d cycles", $time, stuck);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int   len;
		logic rs;
		bit   noisy;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		sample_ch.restart = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset length of 1: every sample is its own window
		send_item(SAMPLE_MIN, 1'b0);
		send_item(SAMPLE_MAX, 1'b0);
		send_item('0, 1'b0);
		send_item(sample_t'(-1), 1'b1);

		set_window_length(3);
		send_item(BIG_POS, 1'b1);
		send_item(BIG_NEG, 1'b0);
		send_item(sample_t'(1), 1'b0);
		send_item(SAMPLE_MAX, 1'b0);
		send_item(SAMPLE_MIN, 1'b0);
		send_item(sample_t'(5), 1'b0);
		send_item(sample_t'(5), 1'b0);
		send_item(sample_t'(5), 1'b0);
		// restart before the window fills
		send_item(sample_t'(7), 1'b1);
		send_item(sample_t'(8), 1'b0);
		send_item(sample_t'(-5), 1'b1);
		send_item(sample_t'(-6), 1'b0);
		send_item(sample_t'(-7), 1'b0);
		send_item(SAMPLE_MAX, 1'b0);
		send_item(SAMPLE_MAX, 1'b1);
		send_item(SAMPLE_MIN, 1'b0);
		send_item(SAMPLE_MIN, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			len = pick_length(p);
			set_window_length(len);
			tx_idle = $urandom_range(0, 2) != 0;
			rx_idle = $urandom_range(0, 2) != 0;
			noisy = $urandom_range(0, 4) == 0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// without a leading restart the new length applies mid-sequence
				if (i == 0)
					rs = $urandom_range(0, 1);
				else if (noisy)
					rs = $urandom_range(0, 2) == 0;
				else
					rs = $urandom_range(0, 49) == 0;
				send_item(pick_sample(), rs);
				if (i == ITEMS_PER_PHASE / 2 && (p == 0 || $urandom_range(0, 1) == 1))
					hold_until_drained();
			end
		end

		sample_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d samples sent under %0d window length settings, %0d min/max items checked",
			items_sent, settings_used, checked);
		$display("lengths covered 0, 1, %0d and values past it, with restarts and receiver stalls",
			MAX_WINDOW);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/swmm_pkg.sv
hdl/swmm_in_if.sv
hdl/swmm_out_if.sv
hdl/swmm_cell.sv
hdl/sliding_window_min_max.sv
hdl/swmm_check.sv
sim/sliding_window_min_max_checker.sv
sim/sliding_window_min_max_test.sv
